FILE: rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types, constants and tables for the box range and bearing core.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  // Field widths
  localparam int COORD_BITS  = 10;
  localparam int ANGLE_STEPS = 14;
  localparam int FOCAL_W     = 12;
  localparam int TARGET_W    = 8;
  localparam int CENTRE_W    = 10;
  localparam int RANGE_W     = 28;
  localparam int BEARING_W   = 16;

  // Configuration port
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTRE = 2'd2;

  localparam int FRAME_COLS = 640;
  localparam logic [FOCAL_W-1:0]  FOCAL_RESET  = FOCAL_W'(1292);
  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(4);
  localparam logic [CENTRE_W-1:0] CENTRE_RESET = CENTRE_W'(FRAME_COLS / 2);

  // Range divider: numerator is target * focal in Q.8, two quotient bits a stage
  localparam int FRAC_BITS  = 8;
  localparam int NUM_W      = TARGET_W + FOCAL_W + FRAC_BITS;
  localparam int DIV_STAGES = NUM_W / 2;

  // Bearing CORDIC
  localparam int DX_W          = (COORD_BITS > CENTRE_W) ? COORD_BITS : CENTRE_W;
  localparam int CORDIC_SCALE  = 20;
  localparam int CORDIC_W      = ((COORD_BITS > FOCAL_W) ? COORD_BITS : FOCAL_W) + 24;
  localparam int Z_W           = 17;
  localparam int TABLE_LEN     = 20;
  localparam int CORDIC_STEPS  = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;
  localparam int BEARING_MAX   = 25736;

  localparam int BACK_STAGES = (DIV_STAGES > CORDIC_STEPS) ? DIV_STAGES : CORDIC_STEPS;

  // Queues
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;
  localparam int OUT_DEPTH   = 2;
  localparam int OUT_PTR_W   = 1;
  localparam int OUT_CNT_W   = 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_min;
    logic [COORD_BITS-1:0] y_min;
    logic [COORD_BITS-1:0] x_max;
    logic [COORD_BITS-1:0] y_max;
  } box_in_t;

  typedef struct packed {
    logic [RANGE_W-1:0]          range_est;
    logic signed [BEARING_W-1:0] bearing;
    logic                        bad_box;
  } box_out_t;

  // Classified box handed from front to back
  typedef struct packed {
    logic                  bad;
    logic                  neg;
    logic                  dx_zero;
    logic [COORD_BITS-1:0] d;
    logic [NUM_W-1:0]      num;
    logic [DX_W-1:0]       dx;
  } brb_task_t;

  // One stage of the back pipeline
  typedef struct packed {
    logic                       bad;
    logic                       neg;
    logic                       dx_zero;
    logic [COORD_BITS-1:0]      d;
    logic [COORD_BITS-1:0]      rem;
    logic [NUM_W-1:0]           shq;
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic signed [Z_W-1:0]      cz;
  } brb_stage_t;

  // atan(2^-i) in radians, Q2.14, rounded to nearest
  function automatic logic [13:0] atan_q14(input int i);
    logic [13:0] a;
    unique case (i)
      0:       a = 14'd12868;
      1:       a = 14'd7596;
      2:       a = 14'd4014;
      3:       a = 14'd2037;
      4:       a = 14'd1023;
      5:       a = 14'd512;
      6:       a = 14'd256;
      7:       a = 14'd128;
      8:       a = 14'd64;
      9:       a = 14'd32;
      10:      a = 14'd16;
      11:      a = 14'd8;
      12:      a = 14'd4;
      13:      a = 14'd2;
      14:      a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/brb_front.sv
// ----------------------------------------------------------------------------
// brb_front
// Accepts boxes, flags bad ones and prepares divider and CORDIC operands.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_front import brb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire box_in_t               box,
  output logic                       full,
  input  wire logic [FOCAL_W-1:0]    focal,
  input  wire logic [TARGET_W-1:0]   target,
  input  wire logic [CENTRE_W-1:0]   centre,
  output logic                       task_valid,
  output brb_task_t                  task_item,
  input  wire logic                  task_ready
);

  logic                          accept;
  logic [COORD_BITS-1:0]         w, h;
  logic [COORD_BITS:0]           sum;
  logic [DX_W-1:0]               mid, cen;
  logic [TARGET_W+FOCAL_W-1:0]   prod;
  brb_task_t                     task_next;

  assign full   = task_valid && !task_ready;
  assign accept = push && !full;

  always_comb begin
    w    = box.x_max - box.x_min;
    h    = box.y_max - box.y_min;
    sum  = {1'b0, box.x_min} + {1'b0, box.x_max};
    mid  = DX_W'(sum[COORD_BITS:1]);
    cen  = DX_W'(centre);
    prod = (TARGET_W+FOCAL_W)'(target) * (TARGET_W+FOCAL_W)'(focal);

    task_next.bad = (box.x_max < box.x_min) || (box.y_max < box.y_min) ||
                    ((box.x_max == box.x_min) && (box.y_max == box.y_min));
    task_next.d       = (w > h) ? w : h;
    task_next.num     = {prod, {FRAC_BITS{1'b0}}};
    task_next.neg     = mid > cen;
    task_next.dx_zero = mid == cen;
    task_next.dx      = (mid > cen) ? (mid - cen) : (cen - mid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_valid <= 1'b0;
    end else if (!full) begin
      task_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      task_item <= task_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/brb_queue.sv
// ----------------------------------------------------------------------------
// brb_queue
// Short task queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_queue import brb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr,
  input  wire brb_task_t  wr_data,
  output logic            q_full,
  input  wire logic       rd,
  output brb_task_t       rd_data,
  output logic            q_empty
);

  brb_task_t            mem [0:Q_DEPTH-1];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_wr, do_rd;

  assign q_full  = count == Q_CNT_W'(Q_DEPTH);
  assign q_empty = count == '0;
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/brb_back.sv
// ----------------------------------------------------------------------------
// brb_back
// Pipelined range divider and bearing CORDIC with a result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_back import brb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [FOCAL_W-1:0]  focal,
  input  wire logic                q_empty,
  input  wire brb_task_t           q_data,
  output logic                     q_rd,
  input  wire logic                pop,
  output logic                     empty,
  output box_out_t                 result
);

  brb_stage_t             stage_q [0:BACK_STAGES];
  logic [BACK_STAGES:0]   vld;
  brb_stage_t             load;
  logic                   advance;

  box_out_t               out_mem [0:OUT_DEPTH-1];
  logic [OUT_PTR_W-1:0]   out_wr_ptr, out_rd_ptr;
  logic [OUT_CNT_W-1:0]   out_count;
  logic                   out_full, out_wr, out_rd;
  box_out_t               out_item;
  brb_stage_t             fin;
  logic [BEARING_W-1:0]   mag;

  // Hold the whole pipeline while the finished item has nowhere to go
  assign out_full = out_count == OUT_CNT_W'(OUT_DEPTH);
  assign advance  = !(vld[BACK_STAGES] && out_full);
  assign q_rd     = advance && !q_empty;

  always_comb begin
    load.bad     = q_data.bad;
    load.neg     = q_data.neg;
    load.dx_zero = q_data.dx_zero;
    load.d       = q_data.d;
    load.rem     = '0;
    load.shq     = q_data.num;
    load.cx      = signed'({{(CORDIC_W-FOCAL_W-CORDIC_SCALE){1'b0}}, focal,
                            {CORDIC_SCALE{1'b0}}});
    load.cy      = signed'({{(CORDIC_W-DX_W-CORDIC_SCALE){1'b0}}, q_data.dx,
                            {CORDIC_SCALE{1'b0}}});
    load.cz      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[BACK_STAGES-1:0], q_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_q[0] <= load;
    end
  end

  for (genvar k = 0; k < BACK_STAGES; k++) begin : g_stage
    logic [COORD_BITS-1:0]      rem_n;
    logic [NUM_W-1:0]           shq_n;
    logic signed [CORDIC_W-1:0] x_n, y_n;
    logic signed [Z_W-1:0]      z_n;
    brb_stage_t                 nxt;

    // Two restoring division steps
    if (k < DIV_STAGES) begin : g_div
      logic [COORD_BITS:0]   t1, t2;
      logic                  ge1, ge2;
      logic [COORD_BITS-1:0] r1;
      logic [NUM_W-1:0]      s1;
      always_comb begin
        t1    = {stage_q[k].rem, stage_q[k].shq[NUM_W-1]};
        ge1   = t1 >= {1'b0, stage_q[k].d};
        r1    = ge1 ? COORD_BITS'(t1 - {1'b0, stage_q[k].d}) : t1[COORD_BITS-1:0];
        s1    = {stage_q[k].shq[NUM_W-2:0], ge1};
        t2    = {r1, s1[NUM_W-1]};
        ge2   = t2 >= {1'b0, stage_q[k].d};
        rem_n = ge2 ? COORD_BITS'(t2 - {1'b0, stage_q[k].d}) : t2[COORD_BITS-1:0];
        shq_n = {s1[NUM_W-2:0], ge2};
      end
    end else begin : g_div_hold
      assign rem_n = stage_q[k].rem;
      assign shq_n = stage_q[k].shq;
    end

    // One CORDIC vectoring rotation, driving y towards zero
    if (k < CORDIC_STEPS) begin : g_rot
      logic signed [CORDIC_W-1:0] xs, ys;
      always_comb begin
        xs = stage_q[k].cx >>> k;
        ys = stage_q[k].cy >>> k;
        if (!stage_q[k].cy[CORDIC_W-1]) begin
          x_n = stage_q[k].cx + ys;
          y_n = stage_q[k].cy - xs;
          z_n = stage_q[k].cz + signed'(Z_W'(atan_q14(k)));
        end else begin
          x_n = stage_q[k].cx - ys;
          y_n = stage_q[k].cy + xs;
          z_n = stage_q[k].cz - signed'(Z_W'(atan_q14(k)));
        end
      end
    end else begin : g_rot_hold
      assign x_n = stage_q[k].cx;
      assign y_n = stage_q[k].cy;
      assign z_n = stage_q[k].cz;
    end

    always_comb begin
      nxt     = stage_q[k];
      nxt.rem = rem_n;
      nxt.shq = shq_n;
      nxt.cx  = x_n;
      nxt.cy  = y_n;
      nxt.cz  = z_n;
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stage_q[k+1] <= nxt;
      end
    end
  end

  // Clamp the angle, apply the side, and zero bad boxes
  assign fin = stage_q[BACK_STAGES];

  always_comb begin
    if (fin.dx_zero || fin.cz < 0) begin
      mag = '0;
    end else if (fin.cz > signed'(Z_W'(BEARING_MAX))) begin
      mag = BEARING_W'(BEARING_MAX);
    end else begin
      mag = BEARING_W'(fin.cz);
    end
    if (fin.bad) begin
      out_item.range_est = '0;
      out_item.bearing   = '0;
      out_item.bad_box   = 1'b1;
    end else begin
      out_item.range_est = RANGE_W'(fin.shq);
      out_item.bearing   = fin.neg ? signed'(-mag) : signed'(mag);
      out_item.bad_box   = 1'b0;
    end
  end

  assign out_wr = advance && vld[BACK_STAGES];
  assign out_rd = pop && !empty;
  assign empty  = out_count == '0;
  assign result = out_mem[out_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (out_wr) begin
        out_wr_ptr <= out_wr_ptr + 1'b1;
      end
      if (out_rd) begin
        out_rd_ptr <= out_rd_ptr + 1'b1;
      end
      unique case ({out_wr, out_rd})
        2'b10:   out_count <= out_count + 1'b1;
        2'b01:   out_count <= out_count - 1'b1;
        default: out_count <= out_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_mem[out_wr_ptr] <= out_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/box_range_and_bearing_core.sv
// ----------------------------------------------------------------------------
// box_range_and_bearing_core
// Range and bearing of a target bounding box under a pinhole camera model.
// ----------------------------------------------------------------------------
// Takes one box per clock while full is low and returns range =
// target_size * focal / d (d the larger of box width and height, unsigned
// Q20.8, floored) and bearing = atan(|centre_x - x_mid| / focal) (signed
// Q2.14 radians, positive when the box centre lies left of centre_x).
// Inverted or zero-size boxes return bad_box with zero range and bearing.
// Sustained rate is one item per cycle while results are popped. The back
// pipeline has fourteen stages that each resolve two quotient bits and one
// CORDIC rotation. The front register, a four-entry task queue and a
// two-entry result queue decouple the two sides, so a held pop stalls the
// pipeline without losing items. Configuration writes are always taken
// (cfg_ready is tied high) and must only be made while the core holds no
// item.
`default_nettype none

module box_range_and_bearing_core import brb_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // box input
  input  wire logic                    push,
  input  wire box_in_t                 box,
  output logic                         full,
  // result output
  output logic                         empty,
  input  wire logic                    pop,
  output box_out_t                     result,
  // configuration writes
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [FOCAL_W-1:0]  focal;
  logic [TARGET_W-1:0] target;
  logic [CENTRE_W-1:0] centre;

  logic       task_valid, task_ready;
  brb_task_t  task_item;
  logic       q_full, q_empty, q_rd;
  brb_task_t  q_data;

  // Configuration registers; writes to an unused index are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal  <= FOCAL_RESET;
      target <= TARGET_RESET;
      centre <= CENTRE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOCAL:  focal  <= cfg_data[FOCAL_W-1:0];
        REG_TARGET: target <= cfg_data[TARGET_W-1:0];
        REG_CENTRE: centre <= cfg_data[CENTRE_W-1:0];
        default: begin
          focal <= focal;
        end
      endcase
    end
  end

  // Front: classify the box and form the divider and CORDIC operands
  brb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .box        (box),
    .full       (full),
    .focal      (focal),
    .target     (target),
    .centre     (centre),
    .task_valid (task_valid),
    .task_item  (task_item),
    .task_ready (task_ready)
  );

  // Hold classified items until the back pipeline can take them
  assign task_ready = !q_full;

  brb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (task_valid),
    .wr_data (task_item),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  // Back: divide and rotate, then queue the finished result
  brb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .focal   (focal),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire
